>>> sv/lkr_pkg.sv
// Shared types and constants for the LRU-K frame replacer.
package lkr_pkg;

    localparam int SLOT_CNT = 16;
    localparam int FID_W    = 4;
    localparam int CNT_W    = 4;
    localparam int EVC_W    = 5;
    localparam int K_W      = 4;

    localparam logic [K_W-1:0] K_RESET = 4'd2;

    typedef enum logic [1:0] {
        FN_ACCESS    = 2'd0,
        FN_SET_EVICT = 2'd1,
        FN_REMOVE    = 2'd2,
        FN_EVICT     = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CELL_NOP    = 2'd0,
        CELL_ACCESS = 2'd1,
        CELL_SETEV  = 2'd2,
        CELL_CLEAR  = 2'd3
    } t_cell_op;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

    typedef struct packed {
        t_func            func;
        logic [FID_W-1:0] target_id;
        logic             evict_flag;
    } t_req;

    typedef struct packed {
        logic             victim_found;
        logic [FID_W-1:0] victim_frame;
        logic             error_flag;
        logic [EVC_W-1:0] evictable_count;
    } t_rsp;

    typedef struct packed {
        t_cell_op op;
        logic     flag;
    } t_cell_cmd;

    typedef struct packed {
        logic tracked;
        logic can_evict;
    } t_cell_stat;

endpackage

>>> sv/lru_k_frame_replacer.sv
// Top level: request control, evictable count and the chain of frame cells.
// Access, set evictable and remove: result registered in the cycle after the
// request; busy stays low, so a request may start every cycle.
// Evict: busy while the best candidate moves down the cell chain one cell per
// cycle, then the result follows.
// Synchronous reset empties every entry and sets k to 2 at once.
module lru_k_frame_replacer #(
    parameter int STAMP_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  lkr_pkg::t_req           i_req,
    input  logic                    i_cfg_we,
    input  logic [lkr_pkg::K_W-1:0] i_cfg_wdata,
    output logic                    o_rsp_valid,
    output lkr_pkg::t_rsp           o_rsp
);

    localparam int NS = lkr_pkg::SLOT_CNT;
    localparam int IW = (NS > 1) ? $clog2(NS) : 1;
    localparam int CW = $clog2(NS + 1);
    localparam int SW = STAMP_WIDTH;

    lkr_pkg::t_state r_state, n_state;
    logic [CW-1:0]            r_cnt;
    logic [lkr_pkg::K_W-1:0]  r_k;
    logic [SW-1:0]            r_stamp;
    logic [lkr_pkg::EVC_W-1:0] r_evcnt, n_evcnt;
    logic                     r_rsp_valid;
    lkr_pkg::t_rsp            r_rsp;

    logic                     accept;
    logic                     scan_done;
    logic                     id_ok;
    logic [lkr_pkg::K_W-1:0]  k_eff;
    lkr_pkg::t_cell_cmd       cmd;
    lkr_pkg::t_cell_stat      addr_stat;
    logic [NS-1:0]            sel;
    logic                     err;

    lkr_pkg::t_cell_stat      stat     [NS];
    logic                     cv       [NS+1];
    logic [SW:0]              ck       [NS+1];
    logic [IW-1:0]            cid      [NS+1];

    assign accept = start & ~busy;
    assign id_ok  = int'(i_req.target_id) < NS;
    assign k_eff  = (r_k == '0) ? lkr_pkg::K_W'(1) : r_k;

    // state machine: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lkr_pkg::ST_IDLE:
                if (accept && i_req.func == lkr_pkg::FN_EVICT) n_state = lkr_pkg::ST_SCAN;
            lkr_pkg::ST_SCAN:
                if (scan_done) n_state = lkr_pkg::ST_IDLE;
            default: n_state = lkr_pkg::ST_IDLE;
        endcase
    end

    // state machine: outputs
    always_comb begin
        busy      = 1'b0;
        scan_done = 1'b0;
        unique case (r_state)
            lkr_pkg::ST_IDLE: begin
            end
            lkr_pkg::ST_SCAN: begin
                busy      = 1'b1;
                scan_done = (r_cnt == CW'(NS));
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        addr_stat = '0;
        for (int i = 0; i < NS; i++) begin
            if (id_ok && int'(i_req.target_id) == i) addr_stat = stat[i];
        end
    end

    // cell command and selection
    always_comb begin
        cmd.op   = lkr_pkg::CELL_NOP;
        cmd.flag = i_req.evict_flag;
        err      = 1'b0;
        n_evcnt  = r_evcnt;
        for (int i = 0; i < NS; i++) begin
            sel[i] = 1'b0;
        end
        if (scan_done) begin
            if (cv[NS]) begin
                cmd.op = lkr_pkg::CELL_CLEAR;
                for (int i = 0; i < NS; i++) begin
                    sel[i] = (int'(cid[NS]) == i);
                end
                if (r_evcnt != '0) n_evcnt = r_evcnt - 1'b1;
            end
        end else if (accept && id_ok) begin
            for (int i = 0; i < NS; i++) begin
                sel[i] = (int'(i_req.target_id) == i);
            end
            unique case (i_req.func)
                lkr_pkg::FN_ACCESS: cmd.op = lkr_pkg::CELL_ACCESS;
                lkr_pkg::FN_SET_EVICT: begin
                    cmd.op = lkr_pkg::CELL_SETEV;
                    if (addr_stat.tracked && addr_stat.can_evict != i_req.evict_flag) begin
                        if (i_req.evict_flag) begin
                            n_evcnt = r_evcnt + 1'b1;
                        end else if (r_evcnt != '0) begin
                            n_evcnt = r_evcnt - 1'b1;
                        end
                    end
                end
                lkr_pkg::FN_REMOVE: begin
                    if (addr_stat.tracked) begin
                        if (!addr_stat.can_evict) begin
                            err = 1'b1;
                        end else begin
                            cmd.op = lkr_pkg::CELL_CLEAR;
                            if (r_evcnt != '0) n_evcnt = r_evcnt - 1'b1;
                        end
                    end
                end
                lkr_pkg::FN_EVICT: cmd.op = lkr_pkg::CELL_NOP;
                default: cmd.op = lkr_pkg::CELL_NOP;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lkr_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_k         <= lkr_pkg::K_RESET;
            r_stamp     <= '0;
            r_evcnt     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_evcnt <= n_evcnt;
            if (i_cfg_we) r_k <= i_cfg_wdata;
            if (accept) begin
                r_cnt <= '0;
            end else if (busy) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (accept && id_ok && i_req.func == lkr_pkg::FN_ACCESS) begin
                r_stamp <= r_stamp + 1'b1;
            end
            r_rsp_valid <= scan_done | (accept && i_req.func != lkr_pkg::FN_EVICT);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp.victim_found    <= scan_done & cv[NS];
        r_rsp.victim_frame    <= (scan_done && cv[NS]) ?
                                 lkr_pkg::FID_W'(cid[NS]) : '0;
        r_rsp.error_flag      <= err;
        r_rsp.evictable_count <= n_evcnt;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // chain head feeds an empty candidate
    assign cv[0]  = 1'b0;
    assign ck[0]  = '0;
    assign cid[0] = '0;

    for (genvar g = 0; g < NS; g++) begin : g_cell
        lkr_cell #(
            .SW(SW),
            .IW(IW),
            .ID(g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_sel       (sel[g]),
            .i_cmd       (cmd),
            .i_k         (k_eff),
            .i_now       (r_stamp),
            .i_cand_valid(cv[g]),
            .i_cand_key  (ck[g]),
            .i_cand_id   (cid[g]),
            .o_cand_valid(cv[g+1]),
            .o_cand_key  (ck[g+1]),
            .o_cand_id   (cid[g+1]),
            .o_stat      (stat[g])
        );
    end

endmodule

>>> sv/lkr_cell.sv
// One frame entry of the replacer, with its stage of the victim search chain.
module lkr_cell #(
    parameter int SW = 32,
    parameter int IW = 4,
    parameter int ID = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_sel,
    input  lkr_pkg::t_cell_cmd     i_cmd,
    input  logic [lkr_pkg::K_W-1:0] i_k,
    input  logic [SW-1:0]          i_now,
    input  logic                   i_cand_valid,
    input  logic [SW:0]            i_cand_key,
    input  logic [IW-1:0]          i_cand_id,
    output logic                   o_cand_valid,
    output logic [SW:0]            o_cand_key,
    output logic [IW-1:0]          o_cand_id,
    output lkr_pkg::t_cell_stat    o_stat
);

    logic                        r_tracked;
    logic                        r_can_evict;
    logic [lkr_pkg::CNT_W-1:0]   r_cnt;
    logic [SW-1:0]               r_stamp;

    logic                        n_tracked;
    logic                        n_can_evict;
    logic [lkr_pkg::CNT_W-1:0]   n_cnt;
    logic [SW-1:0]               n_stamp;

    logic [lkr_pkg::CNT_W-1:0]   base_cnt;
    logic [lkr_pkg::CNT_W-1:0]   inc_cnt;
    logic [SW:0]                 own_key;
    logic                        own_ok;
    logic                        take_own;

    assign base_cnt = r_tracked ? r_cnt : '0;
    assign inc_cnt  = (base_cnt < i_k) ? base_cnt + 1'b1 : base_cnt;

    always_comb begin
        n_tracked   = r_tracked;
        n_can_evict = r_can_evict;
        n_cnt       = r_cnt;
        n_stamp     = r_stamp;
        if (i_sel) begin
            unique case (i_cmd.op)
                lkr_pkg::CELL_ACCESS: begin
                    n_tracked   = 1'b1;
                    n_can_evict = r_tracked & r_can_evict;
                    n_cnt       = inc_cnt;
                    // first-access group keeps its original stamp
                    n_stamp     = (inc_cnt >= i_k || !r_tracked) ? i_now : r_stamp;
                end
                lkr_pkg::CELL_SETEV: begin
                    if (r_tracked) begin
                        n_can_evict = i_cmd.flag;
                    end
                end
                lkr_pkg::CELL_CLEAR: begin
                    n_tracked   = 1'b0;
                    n_can_evict = 1'b0;
                    n_cnt       = '0;
                    n_stamp     = '0;
                end
                lkr_pkg::CELL_NOP: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracked   <= 1'b0;
            r_can_evict <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_tracked   <= n_tracked;
            r_can_evict <= n_can_evict;
            r_cnt       <= n_cnt;
        end
        r_stamp <= n_stamp;
    end

    // Older first-access entries sort below the at-k group; lower ids come
    // down the chain first, so only a strictly smaller key replaces.
    assign own_key  = {(r_cnt >= i_k), r_stamp};
    assign own_ok   = r_tracked & r_can_evict;
    assign take_own = own_ok && (!i_cand_valid || own_key < i_cand_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_cand_valid <= 1'b0;
        end else begin
            o_cand_valid <= i_cand_valid | own_ok;
        end
        o_cand_key <= take_own ? own_key : i_cand_key;
        o_cand_id  <= take_own ? IW'(ID) : i_cand_id;
    end

    assign o_stat.tracked   = r_tracked;
    assign o_stat.can_evict = r_can_evict;

endmodule
